/* rtl/clba_pkg.sv */
// Package: command codes, flag and write-back types for the logic and bit ALU.
package clba_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW = $clog2(RegCount);
  localparam int unsigned CmdW = 4;
  localparam logic [RegIdxW-1:0] AccIdx = RegIdxW'(7);

  typedef enum logic [CmdW-1:0] {
    CMD_AND     = 4'd0,
    CMD_OR      = 4'd1,
    CMD_XOR     = 4'd2,
    CMD_CMP     = 4'd3,
    CMD_SWAP    = 4'd4,
    CMD_BIT     = 4'd5,
    CMD_SET     = 4'd6,
    CMD_RES     = 4'd7,
    CMD_LOAD    = 4'd8
  } cmd_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } wr_t;

endpackage

/* rtl/clba_regfile.sv */
// Eight byte registers with one write port, a selected read port and the accumulator tap.
module clba_regfile import clba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wr_t                wr_i,
  input  logic [RegIdxW-1:0] rd_idx_i,
  output logic [DataW-1:0]   rd_data_o,
  output logic [DataW-1:0]   acc_o
);

  logic [DataW-1:0] regs_q [RegCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      regs_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = regs_q[rd_idx_i];
  assign acc_o     = regs_q[AccIdx];

endmodule

/* rtl/clba_exec.sv */
// Execute logic: result byte, new flags and register write-back for one command.
module clba_exec import clba_pkg::*; (
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [DataW-1:0]   operand_i,
  input  logic [RegIdxW-1:0] reg_sel_i,
  input  logic [2:0]         bit_index_i,
  input  logic [DataW-1:0]   acc_i,
  input  logic [DataW-1:0]   val_i,
  input  flags_t             flags_i,
  output logic [DataW-1:0]   result_o,
  output flags_t             flags_o,
  output wr_t                wr_o
);

  logic [DataW-1:0] mask;
  logic [DataW-1:0] tmp;

  assign mask = DataW'(1) << bit_index_i;

  always_comb begin
    tmp      = '0;
    result_o = acc_i;
    flags_o  = flags_i;
    wr_o     = '{en: 1'b0, idx: AccIdx, data: acc_i};
    case (cmd_i)
      CMD_AND: begin
        tmp      = acc_i & operand_i;
        result_o = tmp;
        flags_o  = '{z: (tmp == '0), n: 1'b0, h: 1'b1, c: 1'b0};
        wr_o     = '{en: 1'b1, idx: AccIdx, data: tmp};
      end
      CMD_OR: begin
        tmp      = acc_i | operand_i;
        result_o = tmp;
        flags_o  = '{z: (tmp == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wr_o     = '{en: 1'b1, idx: AccIdx, data: tmp};
      end
      CMD_XOR: begin
        tmp      = acc_i ^ operand_i;
        result_o = tmp;
        flags_o  = '{z: (tmp == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wr_o     = '{en: 1'b1, idx: AccIdx, data: tmp};
      end
      CMD_CMP: begin
        // borrow out of the full byte and out of the low nibble
        flags_o = '{z: (acc_i == operand_i), n: 1'b1,
                    h: (acc_i[3:0] < operand_i[3:0]), c: (acc_i < operand_i)};
      end
      CMD_SWAP: begin
        tmp      = {val_i[3:0], val_i[7:4]};
        result_o = tmp;
        flags_o  = '{z: (tmp == '0), n: 1'b0, h: 1'b0, c: 1'b0};
        wr_o     = '{en: 1'b1, idx: reg_sel_i, data: tmp};
      end
      CMD_BIT: begin
        result_o = val_i;
        flags_o  = '{z: ((val_i & mask) == '0), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      CMD_SET: begin
        tmp      = val_i | mask;
        result_o = tmp;
        wr_o     = '{en: 1'b1, idx: reg_sel_i, data: tmp};
      end
      CMD_RES: begin
        tmp      = val_i & ~mask;
        result_o = tmp;
        wr_o     = '{en: 1'b1, idx: reg_sel_i, data: tmp};
      end
      CMD_LOAD: begin
        result_o = operand_i;
        wr_o     = '{en: 1'b1, idx: reg_sel_i, data: operand_i};
      end
      default: begin
        result_o = acc_i;
      end
    endcase
  end

endmodule

/* rtl/cpu_logic_and_bit_alu.sv */
// Top level: logic and bit ALU of an 8-bit CPU with register file and flags.
//
// Usage: commands arrive on the slave stream (s_axis_*); each item yields
// exactly one result item on the master stream (m_axis_*) carrying the
// affected register and the Z, N, H and C flags after the command.
// An accepted item lands in an input register; on the next edge at which the
// result register is free (empty or being taken) it executes against the
// register file and flags, which update on that same edge, and the result
// register loads. The result is valid once the result register has loaded,
// and the receiver takes it from there.
// Throughput is one item per cycle unless the receiver stalls: the input
// register takes a new item while the previous one executes, and back-to-back items
// see each other's updates. When the receiver stalls, the result holds, the item
// in the input register waits, and s_axis_tready drops once both are full.
// Reset clears all eight registers, the flags and both valid bits.
module cpu_logic_and_bit_alu import clba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // operand[7:0], reg_sel[10:8], bit_index[13:11], zero pad
  input  logic [3:0]  s_axis_tuser,  // cmd[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // result[7:0], flag_zero[8], flag_subtract[9],
                                     // flag_half[10], flag_carry[11], zero pad
);

  // input register
  logic               in_vld_q;
  logic [CmdW-1:0]    cmd_q;
  logic [DataW-1:0]   operand_q;
  logic [RegIdxW-1:0] reg_sel_q;
  logic [2:0]         bit_index_q;

  // result register
  logic               out_vld_q;
  logic [DataW-1:0]   result_q;
  flags_t             out_flags_q;

  // architectural flags
  flags_t             flags_q;

  logic               out_free;
  logic               exec_fire;
  logic               in_fire;
  logic [DataW-1:0]   acc;
  logic [DataW-1:0]   val;
  logic [DataW-1:0]   result_d;
  flags_t             flags_d;
  wr_t                wr_raw;
  wr_t                wr;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign exec_fire     = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || exec_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (exec_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // capture the incoming item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= s_axis_tuser;
      operand_q   <= s_axis_tdata[7:0];
      reg_sel_q   <= s_axis_tdata[10:8];
      bit_index_q <= s_axis_tdata[13:11];
    end
  end

  clba_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_idx_i  (reg_sel_q),
    .rd_data_o (val),
    .acc_o     (acc)
  );

  clba_exec u_exec (
    .cmd_i       (cmd_q),
    .operand_i   (operand_q),
    .reg_sel_i   (reg_sel_q),
    .bit_index_i (bit_index_q),
    .acc_i       (acc),
    .val_i       (val),
    .flags_i     (flags_q),
    .result_o    (result_d),
    .flags_o     (flags_d),
    .wr_o        (wr_raw)
  );

  // commit state only when the item actually executes
  always_comb begin
    wr    = wr_raw;
    wr.en = wr_raw.en && exec_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        flags_q <= flags_d;
      end
      if (exec_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      result_q    <= result_d;
      out_flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_flags_q.c, out_flags_q.h, out_flags_q.n,
                          out_flags_q.z, result_q};

endmodule

/* tb/testbench.sv */
// Self-checking stream testbench for the logic and bit ALU with its register file.
`timescale 1ns / 100ps

module testbench;
  import clba_pkg::*;

  localparam int unsigned ItemCount   = 1700;
  localparam int unsigned WatchLimit  = 2000;  // cycles with no handshake on either side
  localparam int unsigned DrainCycles = 8;     // margin after the last awaited result
  localparam int unsigned IdlePercent = 26;

  // Command codes outside the defined set; the block must treat them as no-ops.
  localparam logic [CmdW-1:0] CmdSpareLo = 4'd9;
  localparam logic [CmdW-1:0] CmdSpareHi = 4'd15;

  typedef struct packed {
    logic [DataW-1:0] value;
    flags_t           flags;
  } alu_out_t;

  // Shadow copy of the register file and flags; one awaited result per command.
  class alu_result_board;
    logic [DataW-1:0] regs [RegCount];
    flags_t           flags;
    alu_out_t         awaited [$];
    int unsigned      errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      flags  = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Execute one accepted command against the shadow state.
    function void note_command(logic [CmdW-1:0] cmd, logic [DataW-1:0] opnd,
                               logic [RegIdxW-1:0] sel, logic [2:0] bit_no);
      logic [DataW-1:0] acc;
      logic [DataW-1:0] val;
      logic [DataW-1:0] res;
      acc = regs[AccIdx];
      val = regs[sel];
      res = acc;
      case (cmd)
        CMD_AND: begin
          acc = acc & opnd;
          regs[AccIdx] = acc;
          res = acc;
          flags = {acc == 8'h00, 1'b0, 1'b1, 1'b0};
        end
        CMD_OR: begin
          acc = acc | opnd;
          regs[AccIdx] = acc;
          res = acc;
          flags = {acc == 8'h00, 1'b0, 1'b0, 1'b0};
        end
        CMD_XOR: begin
          acc = acc ^ opnd;
          regs[AccIdx] = acc;
          res = acc;
          flags = {acc == 8'h00, 1'b0, 1'b0, 1'b0};
        end
        CMD_CMP: begin
          flags = {acc == opnd, 1'b1, acc[3:0] < opnd[3:0], acc < opnd};
        end
        CMD_SWAP: begin
          val = {val[3:0], val[7:4]};
          regs[sel] = val;
          res = val;
          flags = {val == 8'h00, 1'b0, 1'b0, 1'b0};
        end
        CMD_BIT: begin
          res = val;
          flags = {~val[bit_no], 1'b0, 1'b1, flags.c};
        end
        CMD_SET: begin
          val[bit_no] = 1'b1;
          regs[sel] = val;
          res = val;
        end
        CMD_RES: begin
          val[bit_no] = 1'b0;
          regs[sel] = val;
          res = val;
        end
        CMD_LOAD: begin
          regs[sel] = opnd;
          res = opnd;
        end
        default: res = acc;
      endcase
      awaited.push_back({res, flags});
    endfunction

    task check_result(logic [15:0] data);
      alu_out_t    want;
      logic [3:0]  got_flags;
      string       flag_name [4];
      flag_name = '{"carry", "half", "subtract", "zero"};
      if (awaited.size() == 0) begin
        report($sformatf("result 0x%h with nothing awaited", data));
        return;
      end
      want = awaited.pop_front();
      if (data[7:0] !== want.value)
        report($sformatf("value 0x%h, want 0x%h", data[7:0], want.value));
      got_flags = {data[8], data[9], data[10], data[11]};
      for (int i = 0; i < 4; i++)
        if (got_flags[i] !== want.flags[i])
          report($sformatf("%s flag %b, want %b", flag_name[i], got_flags[i],
                           want.flags[i]));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // operand[7:0], reg_sel[10:8], bit_index[13:11], zero pad
  logic [3:0]  s_axis_tuser;   // cmd[3:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // result[7:0], zero[8], subtract[9], half[10], carry[11]

  logic            calm;         // high: neither side idles
  int unsigned     quiet_cycles;
  alu_result_board board;

  cpu_logic_and_bit_alu u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one item, idling at random first; return once it is accepted.
  task send_command(logic [CmdW-1:0] cmd, logic [DataW-1:0] opnd,
                    logic [RegIdxW-1:0] sel, logic [2:0] bit_no);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, bit_no, sel, opnd};
    // Sample tready at the edge; values seen here are the pre-edge ones.
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(cmd, opnd, sel, bit_no);
  endtask

  // Build a random command, biased toward extremes and equal compares.
  task send_random_command();
    logic [CmdW-1:0]    cmd;
    logic [DataW-1:0]   opnd;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) cmd = CmdW'($urandom_range(CmdSpareLo, CmdSpareHi));
    else cmd = CmdW'($urandom_range(CMD_AND, CMD_LOAD));
    pick = $urandom_range(0, 99);
    if (pick < 6) opnd = 8'h00;
    else if (pick < 12) opnd = 8'hFF;
    else if (pick < 22 && cmd == CMD_CMP) opnd = board.regs[AccIdx];
    else opnd = DataW'($urandom);
    send_command(cmd, opnd, RegIdxW'($urandom_range(0, RegCount - 1)),
                 3'($urandom_range(0, 7)));
  endtask

  // Hold off the sender until every awaited result has been taken.
  task hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: check each accepted result, then choose tready for the next edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed corners, random traffic, drain.
  initial begin
    board         = new();
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Logic ops on the accumulator, including zero results.
    send_command(CMD_LOAD, 8'hFF, AccIdx, 3'd0);
    send_command(CMD_AND,  8'hFF, 3'd0, 3'd0);
    send_command(CMD_AND,  8'h00, 3'd0, 3'd7);
    send_command(CMD_OR,   8'h00, 3'd7, 3'd0);
    send_command(CMD_OR,   8'hFF, 3'd0, 3'd0);
    send_command(CMD_XOR,  8'hFF, 3'd0, 3'd0);
    send_command(CMD_XOR,  8'hA5, 3'd0, 3'd0);
    // Compare: equal, full and half borrow, no borrow, half borrow alone.
    send_command(CMD_CMP,  8'hA5, 3'd0, 3'd0);
    send_command(CMD_CMP,  8'hFF, 3'd0, 3'd0);
    // Bit test must keep the carry left by the compare.
    send_command(CMD_BIT,  8'h00, AccIdx, 3'd7);
    send_command(CMD_CMP,  8'h00, 3'd0, 3'd0);
    send_command(CMD_CMP,  8'h96, 3'd0, 3'd0);
    // Nibble swap, bit test, set and reset, mostly on registers other than the accumulator.
    send_command(CMD_LOAD, 8'h0F, 3'd0, 3'd0);
    send_command(CMD_SWAP, 8'h00, 3'd0, 3'd0);
    send_command(CMD_SWAP, 8'hFF, 3'd1, 3'd0);
    send_command(CMD_BIT,  8'h00, 3'd0, 3'd7);
    send_command(CMD_BIT,  8'h00, 3'd0, 3'd0);
    send_command(CMD_SET,  8'h00, 3'd1, 3'd7);
    send_command(CMD_SET,  8'h00, 3'd2, 3'd0);
    send_command(CMD_RES,  8'h00, 3'd1, 3'd7);
    send_command(CMD_RES,  8'h00, AccIdx, 3'd0);
    // Spare command codes change nothing.
    send_command(CmdSpareLo, 8'hFF, 3'd7, 3'd7);
    send_command(CmdSpareHi, 8'h00, 3'd0, 3'd0);
    send_command(CMD_LOAD, 8'h80, 3'd6, 3'd0);
    send_command(CMD_SWAP, 8'h00, AccIdx, 3'd0);
    hold_until_drained();

    for (int i = 0; i < ItemCount; i++) begin
      calm = (i >= 500 && i < 800);
      if (i == 1100) hold_until_drained();
      send_random_command();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
